### sv/lhc_pkg.sv
// Shared constants, item type and line tables for the link handshake checker.
`timescale 1ns / 1ps

package lhc_pkg;

    localparam int LINE_LIMIT_DEFAULT = 2048;
    localparam int MAP_LENGTH         = 257;
    localparam int MAP_IDX_W          = 9;
    localparam int CODE_W             = 3;
    localparam int BYTE_W             = 8;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Status codes.
    localparam logic [CODE_W-1:0] ST_RUN      = 3'd0;
    localparam logic [CODE_W-1:0] ST_PASS     = 3'd1;
    localparam logic [CODE_W-1:0] ST_NOBANNER = 3'd2;
    localparam logic [CODE_W-1:0] ST_ANTI     = 3'd3;
    localparam logic [CODE_W-1:0] ST_MAPEOF   = 3'd4;
    localparam logic [CODE_W-1:0] ST_MAPBAD   = 3'd5;

    // Phase codes.
    localparam logic [CODE_W-1:0] PH_BANNER = 3'd0;
    localparam logic [CODE_W-1:0] PH_BLANK  = 3'd1;
    localparam logic [CODE_W-1:0] PH_ESCQ   = 3'd2;
    localparam logic [CODE_W-1:0] PH_ESCD   = 3'd3;
    localparam logic [CODE_W-1:0] PH_MAP    = 3'd4;
    localparam logic [CODE_W-1:0] PH_DONE   = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    // One classified beat as it travels through the queue.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eos;
        logic              is_lf;
    } lhc_item_t;

    // Length of the line expected in each line phase.
    function automatic logic [4:0] line_len(input logic [CODE_W-1:0] ph);
        logic [4:0] len;
        unique case (ph)
            PH_BANNER: len = 5'd16;
            PH_BLANK:  len = 5'd1;
            default:   len = 5'd3;
        endcase
        return len;
    endfunction

    // Expected character at a given position of the line for a phase.
    function automatic logic [BYTE_W-1:0] line_char(input logic [CODE_W-1:0] ph,
                                                    input logic [3:0] idx);
        logic [BYTE_W-1:0] ch;
        ch = CHAR_LF;
        unique case (ph)
            PH_BANNER:
            begin
                // Banner text followed by a line feed.
                unique case (idx)
                    4'd0:    ch = 8'h54;
                    4'd1:    ch = 8'h52;
                    4'd2:    ch = 8'h41;
                    4'd3:    ch = 8'h43;
                    4'd4:    ch = 8'h4D;
                    4'd5:    ch = 8'h44;
                    4'd6:    ch = 8'h20;
                    4'd7:    ch = 8'h54;
                    4'd8:    ch = 8'h52;
                    4'd9:    ch = 8'h41;
                    4'd10:   ch = 8'h20;
                    4'd11:   ch = 8'h58;
                    4'd12:   ch = 8'h43;
                    4'd13:   ch = 8'h48;
                    4'd14:   ch = 8'h47;
                    default: ch = CHAR_LF;
                endcase
            end
            PH_ESCQ:
            begin
                unique case (idx)
                    4'd0:    ch = 8'h7E;
                    4'd1:    ch = 8'h3F;
                    default: ch = CHAR_LF;
                endcase
            end
            PH_ESCD:
            begin
                unique case (idx)
                    4'd0:    ch = 8'h7E;
                    4'd1:    ch = 8'h2E;
                    default: ch = CHAR_LF;
                endcase
            end
            default: ch = CHAR_LF;
        endcase
        return ch;
    endfunction

endpackage

### sv/lhc_front.sv
// Front end: accepts input beats, classifies line endings and pushes them to the queue.
`timescale 1ns / 1ps

module lhc_front (
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [lhc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                      end_of_stream,
    input  logic                      q_full,
    output logic                      q_push,
    output lhc_pkg::lhc_item_t        q_item
);
    import lhc_pkg::*;

    // Hold the sender off only while the queue has no room.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // A carriage return counts as a line feed; an end mark carries no byte.
    always_comb
    begin
        q_item.eos   = end_of_stream;
        q_item.data  = end_of_stream ? '0 : rx_byte;
        q_item.is_lf = !end_of_stream && (rx_byte == CHAR_LF || rx_byte == CHAR_CR);
    end

endmodule

### sv/lhc_queue.sv
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module lhc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lhc_pkg::lhc_item_t push_item,
    input  logic               pop,
    output lhc_pkg::lhc_item_t pop_item,
    output logic               full,
    output logic               empty
);
    import lhc_pkg::*;

    lhc_item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/lhc_back.sv
// Back end: line matching, byte map check and the registered result.
`timescale 1ns / 1ps

module lhc_back #(
    parameter int LINE_LIMIT = lhc_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  lhc_pkg::lhc_item_t         q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lhc_pkg::CODE_W-1:0] status,
    output logic [lhc_pkg::CODE_W-1:0] phase,
    output logic                       skipped_line,
    output logic [lhc_pkg::BYTE_W-1:0] expected_byte,
    output logic [lhc_pkg::BYTE_W-1:0] received_byte
);
    import lhc_pkg::*;

    localparam int POS_W = $clog2(LINE_LIMIT);

    logic [CODE_W-1:0]    phase_reg,   phase_next;
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic                 match_reg,   match_next;
    logic [MAP_IDX_W-1:0] map_idx_reg, map_idx_next;
    logic [CODE_W-1:0]    status_reg,  status_next;
    logic                 out_valid_reg;
    logic                 skipped_reg, skipped_next;
    logic [BYTE_W-1:0]    exp_reg,     exp_next;
    logic [BYTE_W-1:0]    recv_reg;

    logic [BYTE_W-1:0]    ch;
    logic [POS_W:0]       pos_ext;
    logic [POS_W:0]       len_ext;
    logic                 ok;
    logic                 hit;
    logic                 line_end;
    logic [MAP_IDX_W-1:0] idx_inc;

    // Take the next beat whenever the output register is free or being drained.
    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    // Per-beat comparison terms for the line phases.
    always_comb
    begin
        ch       = q_item.is_lf ? CHAR_LF : q_item.data;
        pos_ext  = {1'b0, pos_reg};
        len_ext  = (POS_W + 1)'(line_len(phase_reg));
        ok       = match_reg && (pos_ext < len_ext)
                   && (line_char(phase_reg, pos_reg[3:0]) == ch);
        hit      = ok && ((pos_ext + (POS_W + 1)'(1)) == len_ext);
        line_end = q_item.is_lf || (pos_reg == POS_W'(LINE_LIMIT - 1));
        idx_inc  = map_idx_reg + MAP_IDX_W'(1);
    end

    // Next state for the beat being taken.
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        match_next   = match_reg;
        map_idx_next = map_idx_reg;
        status_next  = status_reg;
        skipped_next = 1'b0;
        exp_next     = '0;

        if (phase_reg >= PH_DONE)
        begin
            // Finished: further beats only repeat the verdict.
        end
        else if (phase_reg == PH_MAP)
        begin
            exp_next = map_idx_reg[BYTE_W-1:0];
            if (q_item.eos)
            begin
                status_next = ST_MAPEOF;
                phase_next  = PH_DONE;
            end
            else if (q_item.data != map_idx_reg[BYTE_W-1:0])
            begin
                status_next = ST_MAPBAD;
                phase_next  = PH_DONE;
            end
            else
            begin
                map_idx_next = idx_inc;
                if (idx_inc == MAP_IDX_W'(MAP_LENGTH))
                begin
                    status_next = ST_PASS;
                    phase_next  = PH_DONE;
                end
            end
        end
        else if (q_item.eos)
        begin
            pos_next   = '0;
            match_next = 1'b1;
            phase_next = PH_DONE;
            if (phase_reg == PH_BANNER)
            begin
                status_next  = ST_NOBANNER;
                skipped_next = (pos_reg != '0);
            end
            else
            begin
                status_next = ST_ANTI;
            end
        end
        else if (!line_end)
        begin
            pos_next   = pos_reg + POS_W'(1);
            match_next = ok;
        end
        else
        begin
            pos_next   = '0;
            match_next = 1'b1;
            if (phase_reg == PH_BANNER)
            begin
                if (hit)
                begin
                    phase_next = PH_BLANK;
                end
                else
                begin
                    skipped_next = 1'b1;
                end
            end
            else if (!hit)
            begin
                status_next = ST_ANTI;
                phase_next  = PH_DONE;
            end
            else
            begin
                phase_next = phase_reg + CODE_W'(1);
                if (phase_next == PH_MAP)
                begin
                    map_idx_next = '0;
                end
            end
        end
    end

    // Checker state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BANNER;
            pos_reg       <= '0;
            match_reg     <= 1'b1;
            map_idx_reg   <= '0;
            status_reg    <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                match_reg   <= match_next;
                map_idx_reg <= map_idx_next;
                status_reg  <= status_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            skipped_reg <= skipped_next;
            exp_reg     <= exp_next;
            recv_reg    <= q_item.data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign phase         = phase_reg;
    assign skipped_line  = skipped_reg;
    assign expected_byte = exp_reg;
    assign received_byte = recv_reg;

endmodule

### sv/link_handshake_checker_unit.sv
// Each accepted beat waits in a queue slot; its result is then registered.
// Throughput: one beat per cycle when not stalled; each beat's state update is
// one compare against the expected line character or map byte, plus a counter
// step. The input is stalled only when the two-entry queue is full.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// returns the checker to banner search with a running status.
`timescale 1ns / 1ps

module link_handshake_checker_unit #(
    parameter int LINE_LIMIT = lhc_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lhc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       end_of_stream,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lhc_pkg::CODE_W-1:0] status,
    output logic [lhc_pkg::CODE_W-1:0] phase,
    output logic                       skipped_line,
    output logic [lhc_pkg::BYTE_W-1:0] expected_byte,
    output logic [lhc_pkg::BYTE_W-1:0] received_byte
);
    import lhc_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    lhc_item_t push_item;
    lhc_item_t pop_item;

    lhc_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .end_of_stream (end_of_stream),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    lhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    lhc_back #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .phase         (phase),
        .skipped_line  (skipped_line),
        .expected_byte (expected_byte),
        .received_byte (received_byte)
    );

endmodule

### sv/lhc_checker.sv
// Port-level assertions for the link handshake checker, bound to the top level.
`timescale 1ns / 1ps

module lhc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [lhc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       end_of_stream,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [lhc_pkg::CODE_W-1:0] status,
    input  logic [lhc_pkg::CODE_W-1:0] phase,
    input  logic                       skipped_line,
    input  logic [lhc_pkg::BYTE_W-1:0] expected_byte,
    input  logic [lhc_pkg::BYTE_W-1:0] received_byte
);
    import lhc_pkg::*;

    logic              done_seen_reg;
    logic [CODE_W-1:0] done_status_reg;

    // Remember the verdict once a finished beat has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg   <= 1'b0;
            done_status_reg <= ST_RUN;
        end
        else if (out_valid && !out_stall && phase == PH_DONE && !done_seen_reg)
        begin
            done_seen_reg   <= 1'b1;
            done_status_reg <= status;
        end
    end

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(phase)
            && $stable(received_byte))
        else $error("stalled result beat changed");

    // Once finished, every later beat repeats the same verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_seen_reg |-> phase == PH_DONE && status == done_status_reg)
        else $error("verdict changed after finishing");

    // The status is running exactly while the check has not finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_RUN) == (phase != PH_DONE)))
        else $error("status and phase disagree");

    // A skipped line is only reported during banner search or when it ends it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skipped_line |-> phase == PH_BANNER || phase == PH_DONE)
        else $error("skipped line outside banner search");

endmodule

bind link_handshake_checker_unit lhc_checker u_lhc_checker (.*);

### sim/tb_link_handshake_checker_unit.sv
// Self-checking testbench for the link handshake checker: stimulus, prediction and scoring.
`timescale 1ns / 1ps

module tb_link_handshake_checker_unit;

    import lhc_pkg::*;

    // Ways in which a run may close; one is drawn per run, since reset comes only once.
    localparam int END_EOS_PARTIAL = 0;
    localparam int END_EOS_IDLE    = 1;
    localparam int END_GUARD_EOS   = 2;
    localparam int END_GUARD_BAD   = 3;
    localparam int END_MAP_EOS     = 4;
    localparam int END_MAP_BAD     = 5;
    localparam int END_LAST_CODE   = 7;

    localparam int LINE_CAP    = LINE_LIMIT_DEFAULT;
    localparam int DRAIN_LIMIT = 1000;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct {
        logic [CODE_W-1:0] status;
        logic [CODE_W-1:0] phase;
        logic              skipped;
        logic [BYTE_W-1:0] want_byte;
        logic [BYTE_W-1:0] echo_byte;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_stream;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CODE_W-1:0] status;
    logic [CODE_W-1:0] phase;
    logic              skipped_line;
    logic [BYTE_W-1:0] expected_byte;
    logic [BYTE_W-1:0] received_byte;

    // Text of the lines the checker looks for, each ending in a line feed.
    logic [BYTE_W-1:0] banner_txt [16] = '{8'h54, 8'h52, 8'h41, 8'h43, 8'h4D, 8'h44, 8'h20,
                                           8'h54, 8'h52, 8'h41, 8'h20, 8'h58, 8'h43, 8'h48,
                                           8'h47, 8'h0A};
    logic [BYTE_W-1:0] escq_txt [3] = '{8'h7E, 8'h3F, 8'h0A};
    logic [BYTE_W-1:0] escd_txt [3] = '{8'h7E, 8'h2E, 8'h0A};

    // Predicted checker state.
    logic [CODE_W-1:0] chk_phase;
    logic [CODE_W-1:0] chk_status;
    int                line_pos;
    logic              line_good;
    int                map_pos;

    verdict_t verdict_q[$];
    verdict_t head;
    int       fails = 0;
    int       ending;
    bit       idle_on = 1'b1;
    int       stall_left = 0;

    link_handshake_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .phase        (phase),
        .skipped_line (skipped_line),
        .expected_byte(expected_byte),
        .received_byte(received_byte)
    );

    always #10 clk = ~clk;

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic is_eol(input logic [BYTE_W-1:0] v);
        return (v == CHAR_LF) || (v == CHAR_CR);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_eol();
        return ($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_text_byte();
        logic [BYTE_W-1:0] v;
        do
            v = rand_byte();
        while (is_eol(v));
        return v;
    endfunction

    function automatic int line_size(input logic [CODE_W-1:0] ph);
        int n;
        if (ph == PH_BANNER)
            n = 16;
        else if (ph == PH_BLANK)
            n = 1;
        else
            n = 3;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] line_byte(input logic [CODE_W-1:0] ph, input int pos);
        logic [BYTE_W-1:0] ch;
        ch = CHAR_LF;
        if (ph == PH_BANNER && pos < 16)
            ch = banner_txt[pos];
        else if (ph == PH_ESCQ && pos < 3)
            ch = escq_txt[pos];
        else if (ph == PH_ESCD && pos < 3)
            ch = escd_txt[pos];
        return ch;
    endfunction

    // The line a phase waits for, closed by either a line feed or a carriage return.
    function automatic byte_q_t expected_line(input logic [CODE_W-1:0] ph);
        byte_q_t txt;
        for (int pos = 0; pos < line_size(ph) - 1; pos++)
            txt.push_back(line_byte(ph, pos));
        txt.push_back(rand_eol());
        return txt;
    endfunction

    task automatic close_session(input logic [CODE_W-1:0] st);
        chk_status = st;
        chk_phase  = PH_DONE;
        line_pos   = 0;
        line_good  = 1'b1;
    endtask

    // Advance the predicted state by one accepted beat and queue the result it gives.
    task automatic track_beat(input logic [BYTE_W-1:0] b, input logic eos);
        verdict_t          v;
        logic [BYTE_W-1:0] c;
        int                len;
        logic              ok;
        logic              line_over;
        v.skipped   = 1'b0;
        v.want_byte = '0;
        if (chk_phase == PH_MAP)
        begin
            // Raw byte map: no line handling at all.
            v.want_byte = map_pos[BYTE_W-1:0];
            if (eos)
                close_session(ST_MAPEOF);
            else if (b != map_pos[BYTE_W-1:0])
                close_session(ST_MAPBAD);
            else
            begin
                map_pos++;
                if (map_pos >= MAP_LENGTH)
                    close_session(ST_PASS);
            end
        end
        else if (chk_phase < PH_MAP)
        begin
            len = line_size(chk_phase);
            if (eos)
            begin
                if (chk_phase == PH_BANNER)
                begin
                    v.skipped = (line_pos != 0);
                    close_session(ST_NOBANNER);
                end
                else
                    close_session(ST_ANTI);
            end
            else
            begin
                // Carriage return is taken as a line feed; the verdict waits for the line end.
                c         = (b == CHAR_CR) ? CHAR_LF : b;
                ok        = line_good && line_pos < len && line_byte(chk_phase, line_pos) == c;
                line_over = (c == CHAR_LF) || (line_pos + 1 >= LINE_CAP);
                if (!line_over)
                begin
                    line_pos  = (line_pos + 1) & 'hFFF;
                    line_good = ok;
                end
                else
                begin
                    ok        = ok && (line_pos + 1 == len);
                    line_pos  = 0;
                    line_good = 1'b1;
                    if (chk_phase == PH_BANNER)
                    begin
                        if (ok)
                            chk_phase = PH_BLANK;
                        else
                            v.skipped = 1'b1;
                    end
                    else if (!ok)
                        close_session(ST_ANTI);
                    else
                    begin
                        chk_phase = chk_phase + 3'd1;
                        if (chk_phase == PH_MAP)
                            map_pos = 0;
                    end
                end
            end
        end
        v.status    = chk_status;
        v.phase     = chk_phase;
        v.echo_byte = eos ? '0 : b;
        verdict_q.push_back(v);
    endtask

    // Offer one beat, with an optional idle burst first, and hold it until it is taken.
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eos);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid      = 1'b0;
            rx_byte       = rand_byte();
            end_of_stream = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid      = 1'b1;
        rx_byte       = b;
        end_of_stream = eos;
        do
            @(posedge clk);
        while (in_stall);
        track_beat(b, eos);
    endtask

    task automatic send_line(input byte_q_t txt);
        foreach (txt[i])
            send_beat(txt[i], 1'b0);
    endtask

    // Byte extremes, a lone carriage return, a banner fragment and a CR LF pair.
    task automatic test_short_lines();
        send_line('{8'h00, 8'hFF, CHAR_LF});
        send_line('{CHAR_CR});
        send_line('{banner_txt[0], CHAR_CR});
        send_line('{CHAR_CR, CHAR_LF});
    endtask

    // Random lines and near misses of the banner while the search goes on.
    task automatic test_banner_noise(input int target);
        byte_q_t           txt;
        int                sent;
        int                pos;
        int                n;
        logic [BYTE_W-1:0] v;
        sent = 0;
        while (sent < target)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            txt.delete();
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    n = $urandom_range(0, 30);
                    repeat (n) txt.push_back(rand_text_byte());
                    txt.push_back(rand_eol());
                end
                2:
                begin
                    txt = expected_line(PH_BANNER);
                    pos = $urandom_range(0, 14);
                    do
                        v = rand_byte();
                    while (v == txt[pos]);
                    txt[pos] = v;
                end
                3:
                begin
                    txt = expected_line(PH_BANNER);
                    n   = $urandom_range(0, 14);
                    while (txt.size() > n)
                        void'(txt.pop_back());
                    txt.push_back(rand_eol());
                end
                4:
                begin
                    txt = expected_line(PH_BANNER);
                    txt.insert($urandom_range(0, 15), rand_text_byte());
                end
                default:
                begin
                    n = $urandom_range(1, 24);
                    repeat (n) txt.push_back(rand_byte());
                    txt.push_back(rand_eol());
                end
            endcase
            send_line(txt);
            sent += txt.size();
        end
        idle_on = 1'b1;
    endtask

    // The stream closes before any banner, with or without a partial line.
    task automatic test_close_in_search();
        if (ending == END_EOS_PARTIAL)
            repeat ($urandom_range(1, 10)) send_beat(rand_text_byte(), 1'b0);
        send_beat(rand_byte(), 1'b1);
    endtask

    // The banner itself, closed by either terminator.
    task automatic test_banner_accept();
        send_line(expected_line(PH_BANNER));
    endtask

    // The three guard lines, one of them cut short or spoilt where the run ends there.
    task automatic test_guard_lines();
        byte_q_t           txt;
        logic [CODE_W-1:0] ph;
        logic [CODE_W-1:0] bad_ph;
        int                pos;
        logic [BYTE_W-1:0] v;
        bad_ph = CODE_W'($urandom_range(PH_BLANK, PH_ESCD));
        for (ph = PH_BLANK; ph <= PH_ESCD; ph++)
        begin
            txt = expected_line(ph);
            if (ph == bad_ph && ending == END_GUARD_EOS)
            begin
                pos = $urandom_range(0, txt.size() - 1);
                for (int i = 0; i < pos; i++)
                    send_beat(txt[i], 1'b0);
                send_beat(rand_byte(), 1'b1);
                return;
            end
            if (ph == bad_ph && ending == END_GUARD_BAD)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // A changed byte; a terminator never turns into the other terminator.
                    pos = $urandom_range(0, txt.size() - 1);
                    do
                        v = rand_byte();
                    while (v == txt[pos] || (is_eol(txt[pos]) && is_eol(v)));
                    txt[pos] = v;
                    if (!is_eol(txt[txt.size() - 1]))
                        txt.push_back(CHAR_LF);
                end
                else
                    txt.insert($urandom_range(0, txt.size() - 1), rand_text_byte());
                send_line(txt);
                return;
            end
            send_line(txt);
        end
    endtask

    // The byte map, cut short or broken at a random place where the run ends there.
    task automatic test_byte_map();
        int                stop_at;
        logic [BYTE_W-1:0] v;
        stop_at = $urandom_range(0, MAP_LENGTH - 1);
        for (int i = 0; i < MAP_LENGTH; i++)
        begin
            if (i % 32 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i == stop_at && ending == END_MAP_EOS)
            begin
                send_beat(rand_byte(), 1'b1);
                return;
            end
            if (i == stop_at && ending == END_MAP_BAD)
            begin
                do
                    v = rand_byte();
                while (v == i[BYTE_W-1:0]);
                send_beat(v, 1'b0);
                return;
            end
            send_beat(i[BYTE_W-1:0], 1'b0);
        end
        idle_on = 1'b1;
    endtask

    // Beats after the verdict must leave it unchanged; no idling in this last stretch.
    task automatic test_after_finish();
        idle_on = 1'b0;
        repeat (60) send_beat(rand_byte(), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Result side stalls in random bursts while idling is on.
    always @(negedge clk)
    begin
        if (!idle_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no prediction pending");
                fails++;
            end
            else
            begin
                head = verdict_q.pop_front();
                check_field("status", BYTE_W'(head.status), BYTE_W'(status));
                check_field("phase", BYTE_W'(head.phase), BYTE_W'(phase));
                check_field("skipped_line", BYTE_W'(head.skipped), BYTE_W'(skipped_line));
                check_field("expected_byte", head.want_byte, expected_byte);
                check_field("received_byte", head.echo_byte, received_byte);
            end
        end
    end

    initial
    begin
        int wait_cycles;
        in_valid      = 1'b0;
        rx_byte       = '0;
        end_of_stream = 1'b0;
        rst_n         = 1'b0;
        chk_phase     = PH_BANNER;
        chk_status    = ST_RUN;
        line_pos      = 0;
        line_good     = 1'b1;
        map_pos       = 0;
        ending        = $urandom_range(0, END_LAST_CODE);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_short_lines();
        if (ending <= END_EOS_IDLE)
        begin
            test_banner_noise(1100);
            test_close_in_search();
        end
        else
        begin
            test_banner_noise(850);
            test_banner_accept();
            test_guard_lines();
            if (ending >= END_MAP_EOS)
                test_byte_map();
        end
        test_after_finish();

        // Let the last results drain, then keep watching for strays.
        @(negedge clk);
        in_valid    = 1'b0;
        wait_cycles = 0;
        while (verdict_q.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", verdict_q.size());
            fails++;
        end
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
sv/lhc_pkg.sv
sv/lhc_front.sv
sv/lhc_queue.sv
sv/lhc_back.sv
sv/link_handshake_checker_unit.sv
sv/lhc_checker.sv
sim/tb_link_handshake_checker_unit.sv
